>>> design/tbp_pkg.sv
package tbp_pkg;

	localparam int LOCAL_HIST_ENTRIES_DEF  = 2048;
	localparam int LOCAL_PRED_ENTRIES_DEF  = 2048;
	localparam int GLOBAL_PRED_ENTRIES_DEF = 8192;
	localparam int CHOICE_PRED_ENTRIES_DEF = 8192;
	localparam int CTR_BITS_DEF            = 2;

	localparam int             SHIFT_W         = 5;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd2;

endpackage

>>> design/tbp_ram.sv
module tbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/tournament_branch_predictor.sv
// A word is taken at the clock edge where start is high and busy is low; its result
// strobes done for one cycle, registered from the result step. busy stays high from
// each accept until the result step ends, so a new word is taken only after the last
// has passed five registered steps: shift and reciprocal multiply, remainder, fold and
// local history read, local counter read, result. After arst_n, busy holds while all
// tables are swept to zero; pc_shift resets to 2 and may be written meanwhile. Results cannot be held off.
module tournament_branch_predictor #(
	parameter int LOCAL_HIST_ENTRIES  = tbp_pkg::LOCAL_HIST_ENTRIES_DEF,
	parameter int LOCAL_PRED_ENTRIES  = tbp_pkg::LOCAL_PRED_ENTRIES_DEF,
	parameter int GLOBAL_PRED_ENTRIES = tbp_pkg::GLOBAL_PRED_ENTRIES_DEF,
	parameter int CHOICE_PRED_ENTRIES = tbp_pkg::CHOICE_PRED_ENTRIES_DEF,
	parameter int CTR_BITS            = tbp_pkg::CTR_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tbp_pkg::SHIFT_W-1:0] cfg_wdata,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [31:0]                 branch_pc,
	input  logic                        outcome_taken,
	output logic                        done,
	output logic                        predict_taken,
	output logic                        local_guess,
	output logic                        global_guess,
	output logic                        used_global
);

	import tbp_pkg::*;

	localparam int LHAW = $clog2(LOCAL_HIST_ENTRIES);
	localparam int LHW  = $clog2(LOCAL_PRED_ENTRIES);
	localparam int GAW  = $clog2(GLOBAL_PRED_ENTRIES);
	localparam int CAW  = $clog2(CHOICE_PRED_ENTRIES);
	localparam int GHW  = (GAW > CAW) ? GAW : CAW;

	localparam int MAXD_A = (LOCAL_HIST_ENTRIES > LOCAL_PRED_ENTRIES) ?
		LOCAL_HIST_ENTRIES : LOCAL_PRED_ENTRIES;
	localparam int MAXD_B = (GLOBAL_PRED_ENTRIES > CHOICE_PRED_ENTRIES) ?
		GLOBAL_PRED_ENTRIES : CHOICE_PRED_ENTRIES;
	localparam int MAXD   = (MAXD_A > MAXD_B) ? MAXD_A : MAXD_B;
	localparam int CLRW   = $clog2(MAXD);

	// floor(2^32 / entries); quotient estimate is low by at most one
	localparam logic [63:0] LH_RECIP64 = 64'h1_0000_0000 / LOCAL_HIST_ENTRIES;
	localparam logic [31:0] LH_RECIP   = LH_RECIP64[31:0];

	// weight of the history bit that falls off the top, reduced per table
	localparam int G_DROP = (1 << GHW) % GLOBAL_PRED_ENTRIES;
	localparam int C_DROP = (1 << GHW) % CHOICE_PRED_ENTRIES;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MUL, S_FOLD, S_LP, S_RES} state_t;

	function automatic logic [CTR_BITS-1:0] ctr_train(input logic [CTR_BITS-1:0] c,
			input logic up);
		logic [CTR_BITS-1:0] r;
		r = c;
		if (up) begin
			if (c != {CTR_BITS{1'b1}}) r = CTR_BITS'(c + 1'b1);
		end else begin
			if (c != '0) r = CTR_BITS'(c - 1'b1);
		end
		return r;
	endfunction

	state_t              state_q;
	logic [CLRW-1:0]     clr_q;
	logic [SHIFT_W-1:0]  pc_shift_q;
	logic [GHW-1:0]      ghr_q;
	logic [GAW-1:0]      g_idx_q;
	logic [CAW-1:0]      c_idx_q;

	logic                func_q;
	logic                taken_q;
	logic [31:0]         x_q;
	logic [63:0]         prod_q;
	logic [LHAW:0]       rem_q;
	logic [LHAW-1:0]     lh_idx_q;
	logic [LHW-1:0]      lp_idx_q;

	logic                accept;
	logic                clearing;
	logic [31:0]         x_d;
	logic [63:0]         prod_d;
	logic [31:0]         qm_d;
	logic [31:0]         rem_full;
	logic [LHAW-1:0]     lh_idx_d;
	logic [LHW-1:0]      lp_idx_d;
	logic [GAW:0]        g_v, g_w;
	logic [GAW-1:0]      g_next;
	logic [CAW:0]        c_v, c_w;
	logic [CAW-1:0]      c_next;
	logic                upd_wr;
	logic                lg, gg, ug;

	logic                lh_we, lc_we, gc_we, ch_we;
	logic [LHAW-1:0]     lh_waddr;
	logic [LHW-1:0]      lc_waddr;
	logic [GAW-1:0]      gc_waddr;
	logic [CAW-1:0]      ch_waddr;
	logic [LHW-1:0]      lh_wdata, lh_rdata;
	logic [CTR_BITS-1:0] lc_wdata, lc_rdata;
	logic [CTR_BITS-1:0] gc_wdata, gc_rdata;
	logic [CTR_BITS-1:0] ch_wdata, ch_rdata;

	assign clearing = (state_q == S_CLEAR);
	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;

	// address stage arithmetic: index = (pc >> shift) mod entries
	assign x_d      = branch_pc >> pc_shift_q;
	assign prod_d   = x_d * LH_RECIP;
	assign qm_d     = 32'(prod_q[63:32] * 32'(LOCAL_HIST_ENTRIES));
	assign rem_full = x_q - qm_d;
	assign lh_idx_d = (rem_q >= (LHAW+1)'(LOCAL_HIST_ENTRIES)) ?
		LHAW'(rem_q - (LHAW+1)'(LOCAL_HIST_ENTRIES)) : rem_q[LHAW-1:0];
	assign lp_idx_d = ({1'b0, lh_rdata} >= (LHW+1)'(LOCAL_PRED_ENTRIES)) ?
		LHW'({1'b0, lh_rdata} - (LHW+1)'(LOCAL_PRED_ENTRIES)) : lh_rdata;

	// keep history mod each table size in step with the shift
	always_comb begin
		g_v = {g_idx_q, taken_q};
		g_w = g_v;
		if (ghr_q[GHW-1]) begin
			if (g_v >= (GAW+1)'(G_DROP)) g_w = g_v - (GAW+1)'(G_DROP);
			else g_w = g_v + (GAW+1)'(GLOBAL_PRED_ENTRIES - G_DROP);
		end
		g_next = (g_w >= (GAW+1)'(GLOBAL_PRED_ENTRIES)) ?
			GAW'(g_w - (GAW+1)'(GLOBAL_PRED_ENTRIES)) : g_w[GAW-1:0];
	end

	always_comb begin
		c_v = {c_idx_q, taken_q};
		c_w = c_v;
		if (ghr_q[GHW-1]) begin
			if (c_v >= (CAW+1)'(C_DROP)) c_w = c_v - (CAW+1)'(C_DROP);
			else c_w = c_v + (CAW+1)'(CHOICE_PRED_ENTRIES - C_DROP);
		end
		c_next = (c_w >= (CAW+1)'(CHOICE_PRED_ENTRIES)) ?
			CAW'(c_w - (CAW+1)'(CHOICE_PRED_ENTRIES)) : c_w[CAW-1:0];
	end

	assign lg     = lc_rdata[CTR_BITS-1];
	assign gg     = gc_rdata[CTR_BITS-1];
	assign ug     = ch_rdata[CTR_BITS-1];
	assign upd_wr = (state_q == S_RES) && func_q;

	// write ports: sweep after reset, otherwise write-back of the trained entry
	always_comb begin
		lh_we    = upd_wr;
		lc_we    = upd_wr;
		gc_we    = upd_wr;
		ch_we    = upd_wr && (lg != gg);
		lh_waddr = lh_idx_q;
		lc_waddr = lp_idx_q;
		gc_waddr = g_idx_q;
		ch_waddr = c_idx_q;
		lh_wdata = LHW'({lh_rdata, taken_q});
		lc_wdata = ctr_train(lc_rdata, taken_q);
		gc_wdata = ctr_train(gc_rdata, taken_q);
		ch_wdata = ctr_train(ch_rdata, lg != taken_q);
		if (clearing) begin
			lh_we    = ({1'b0, clr_q} < (CLRW+1)'(LOCAL_HIST_ENTRIES));
			lc_we    = ({1'b0, clr_q} < (CLRW+1)'(LOCAL_PRED_ENTRIES));
			gc_we    = ({1'b0, clr_q} < (CLRW+1)'(GLOBAL_PRED_ENTRIES));
			ch_we    = ({1'b0, clr_q} < (CLRW+1)'(CHOICE_PRED_ENTRIES));
			lh_waddr = clr_q[LHAW-1:0];
			lc_waddr = clr_q[LHW-1:0];
			gc_waddr = clr_q[GAW-1:0];
			ch_waddr = clr_q[CAW-1:0];
			lh_wdata = '0;
			lc_wdata = '0;
			gc_wdata = '0;
			ch_wdata = '0;
		end
	end

	tbp_ram #(.WIDTH(LHW), .DEPTH(LOCAL_HIST_ENTRIES)) u_lhist (
		.clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
		.re(state_q == S_FOLD), .raddr(lh_idx_d), .rdata(lh_rdata)
	);

	tbp_ram #(.WIDTH(CTR_BITS), .DEPTH(LOCAL_PRED_ENTRIES)) u_lctr (
		.clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
		.re(state_q == S_LP), .raddr(lp_idx_d), .rdata(lc_rdata)
	);

	tbp_ram #(.WIDTH(CTR_BITS), .DEPTH(GLOBAL_PRED_ENTRIES)) u_gctr (
		.clk(clk), .we(gc_we), .waddr(gc_waddr), .wdata(gc_wdata),
		.re(accept), .raddr(g_idx_q), .rdata(gc_rdata)
	);

	tbp_ram #(.WIDTH(CTR_BITS), .DEPTH(CHOICE_PRED_ENTRIES)) u_cctr (
		.clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
		.re(accept), .raddr(c_idx_q), .rdata(ch_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			pc_shift_q    <= SHIFT_RESET;
			ghr_q         <= '0;
			g_idx_q       <= '0;
			c_idx_q       <= '0;
			done          <= 1'b0;
			predict_taken <= 1'b0;
			local_guess   <= 1'b0;
			global_guess  <= 1'b0;
			used_global   <= 1'b0;
		end else begin
			done <= (state_q == S_RES);
			if (cfg_we) begin
				pc_shift_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= CLRW'(clr_q + 1'b1);
					if (clr_q == CLRW'(MAXD - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_FOLD;
				S_FOLD: state_q <= S_LP;
				S_LP:   state_q <= S_RES;
				S_RES: begin
					state_q       <= S_IDLE;
					predict_taken <= ug ? gg : lg;
					local_guess   <= lg;
					global_guess  <= gg;
					used_global   <= ug;
					if (func_q) begin
						ghr_q   <= GHW'({ghr_q, taken_q});
						g_idx_q <= g_next;
						c_idx_q <= c_next;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			taken_q <= outcome_taken;
			x_q     <= x_d;
			prod_q  <= prod_d;
		end
		if (state_q == S_MUL) begin
			rem_q <= rem_full[LHAW:0];
		end
		if (state_q == S_FOLD) begin
			lh_idx_q <= lh_idx_d;
		end
		if (state_q == S_LP) begin
			lp_idx_q <= lp_idx_d;
		end
	end

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("result strobe missing five edges after accept");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_RES))
		else $error("result strobe without a finished word");

	a_pick: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (predict_taken == (used_global ? global_guess : local_guess)))
		else $error("combined prediction does not follow choice");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import tbp_pkg::*;

	localparam int LH_N = LOCAL_HIST_ENTRIES_DEF;
	localparam int LP_N = LOCAL_PRED_ENTRIES_DEF;
	localparam int GP_N = GLOBAL_PRED_ENTRIES_DEF;
	localparam int CP_N = CHOICE_PRED_ENTRIES_DEF;
	localparam int CW   = CTR_BITS_DEF;
	localparam int LH_W = $clog2(LP_N);
	localparam int GH_W = ($clog2(GP_N) > $clog2(CP_N)) ? $clog2(GP_N) : $clog2(CP_N);
	localparam int CTR_MAX = (1 << CW) - 1;
	localparam int CTR_THR = (1 << (CW - 1)) - 1;
	localparam int MAX_SHOWN = 10;

	typedef enum logic {
		LOOKUP = 1'b0,
		UPDATE = 1'b1
	} branch_op_t;

	typedef struct packed {
		logic predict;
		logic loc;
		logic glob;
		logic sel;
	} guess_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [SHIFT_W-1:0]  cfg_wdata;
	logic                start;
	logic                busy;
	logic                func;
	logic [31:0]         branch_pc;
	logic                outcome_taken;
	logic                done;
	logic                predict_taken;
	logic                local_guess;
	logic                global_guess;
	logic                used_global;

	// shadow predictor state
	bit [LH_W-1:0]    loc_hist [LH_N];
	bit [CW-1:0]      loc_ctr  [LP_N];
	bit [CW-1:0]      glob_ctr [GP_N];
	bit [CW-1:0]      sel_ctr  [CP_N];
	bit [GH_W-1:0]    glob_hist;
	bit [SHIFT_W-1:0] shift_q = SHIFT_RESET;

	guess_t guess_q[$];
	bit     idle_on = 1'b1;
	int     err_cnt = 0;
	int     n_words = 0;
	int     n_updates = 0;
	int     n_results = 0;
	int     n_global_sel = 0;
	int     n_shifts = 0;

	tournament_branch_predictor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.branch_pc     (branch_pc),
		.outcome_taken (outcome_taken),
		.done          (done),
		.predict_taken (predict_taken),
		.local_guess   (local_guess),
		.global_guess  (global_guess),
		.used_global   (used_global)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Timeout at %0t", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit [CW-1:0] bump(bit [CW-1:0] c, bit up);
		if (up)
			return (c == CTR_MAX) ? c : c + 1'b1;
		return (c == 0) ? c : c - 1'b1;
	endfunction

	// guesses come from the tables as they stand before this word
	function automatic guess_t resolve_branch(branch_op_t op, logic [31:0] pc, logic taken);
		int unsigned lh_i, lp_i, g_i, c_i;
		guess_t g;
		lh_i = (pc >> shift_q) % LH_N;
		lp_i = loc_hist[lh_i] % LP_N;
		g_i = glob_hist % GP_N;
		c_i = glob_hist % CP_N;
		g.loc = loc_ctr[lp_i] > CTR_THR;
		g.glob = glob_ctr[g_i] > CTR_THR;
		g.sel = sel_ctr[c_i] > CTR_THR;
		g.predict = g.sel ? g.glob : g.loc;
		if (op == UPDATE) begin
			if (g.loc != g.glob)
				sel_ctr[c_i] = bump(sel_ctr[c_i], g.loc != taken);
			glob_ctr[g_i] = bump(glob_ctr[g_i], taken);
			loc_ctr[lp_i] = bump(loc_ctr[lp_i], taken);
			glob_hist = {glob_hist[GH_W-2:0], taken};
			loc_hist[lh_i] = {loc_hist[lh_i][LH_W-2:0], taken};
		end
		return g;
	endfunction

	function automatic int gap_pick();
		if (!idle_on)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
	endfunction

	function automatic void flag(string msg);
		err_cnt++;
		if (err_cnt <= MAX_SHOWN)
			$display("ERROR %0t: %s", $time, msg);
	endfunction

	// called at a falling edge; returns at a falling edge, start left high if no gap
	task automatic send_word(branch_op_t op, logic [31:0] pc, logic taken, int gap);
		func = op;
		branch_pc = pc;
		outcome_taken = taken;
		start = 1'b1;
		do @(posedge clk); while (busy);
		guess_q.push_back(resolve_branch(op, pc, taken));
		n_words++;
		if (op == UPDATE)
			n_updates++;
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic set_shift(logic [SHIFT_W-1:0] v);
		start = 1'b0;
		while (guess_q.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		shift_q = v;
		n_shifts++;
	endtask

	always @(posedge clk) begin
		guess_t got, exp_g;
		if (arst_n && done) begin
			got = {predict_taken, local_guess, global_guess, used_global};
			n_results++;
			if (used_global === 1'b1)
				n_global_sel++;
			if (guess_q.size() == 0) begin
				flag($sformatf("result with nothing outstanding: pred=%b loc=%b glob=%b sel=%b",
					got.predict, got.loc, got.glob, got.sel));
			end else begin
				exp_g = guess_q.pop_front();
				if (got.predict !== exp_g.predict || got.loc !== exp_g.loc ||
				    got.glob !== exp_g.glob || got.sel !== exp_g.sel)
					flag($sformatf("expected pred=%b loc=%b glob=%b sel=%b, got pred=%b loc=%b glob=%b sel=%b",
						exp_g.predict, exp_g.loc, exp_g.glob, exp_g.sel,
						got.predict, got.loc, got.glob, got.sel));
			end
		end
	end

	// fresh tables: decrement at zero, address extremes, outcome ignored on lookup
	task automatic test_fresh_tables();
		set_shift(SHIFT_RESET);
		send_word(UPDATE, 32'h0000_0000, 1'b0, 0);
		send_word(LOOKUP, 32'hFFFF_FFFF, 1'b1, 0);
		send_word(UPDATE, 32'hFFFF_FFFF, 1'b1, 3);
		send_word(LOOKUP, 32'h0000_0000, 1'b0, 0);
	endtask

	// one branch always taken: histories fill with ones, counters pin at max
	task automatic test_counter_saturation();
		for (int i = 0; i < 15; i++)
			send_word(UPDATE, 32'h0000_1234, 1'b1, (i % 4 == 0) ? 2 : 0);
		send_word(LOOKUP, 32'h0000_1234, 1'b0, 0);
		// now not taken: guesses still agree, so choice counters do not move
		send_word(UPDATE, 32'h0000_1234, 1'b0, 0);
		send_word(UPDATE, 32'h0000_1234, 1'b0, 0);
	endtask

	task automatic test_shift_extremes();
		set_shift(5'd31);
		send_word(UPDATE, 32'h8000_0000, 1'b1, 0);
		send_word(LOOKUP, 32'h7FFF_FFFF, 1'b0, 0);
		set_shift(5'd0);
		send_word(UPDATE, 32'hFFFF_FFFF, 1'b0, 0);
		send_word(LOOKUP, 32'h0000_07FF, 1'b1, 0);
	endtask

	// mostly loop-like branches from a small pool, lookup then resolve, plus noise
	task automatic test_branch_stream(int n);
		logic [31:0] pool_pc [8];
		int          pool_per [8];
		int          pool_iter [8];
		int          cnt, s, r;
		logic        t;
		for (int i = 0; i < 8; i++) begin
			pool_pc[i] = $urandom();
			pool_per[i] = $urandom_range(1, 7);
			pool_iter[i] = 0;
		end
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				s = $urandom_range(0, 7);
				t = (pool_per[s] == 1) ? 1'b1 : (pool_iter[s] % pool_per[s] != pool_per[s] - 1);
				pool_iter[s]++;
				if ($urandom_range(0, 1)) begin
					send_word(LOOKUP, pool_pc[s], 1'($urandom_range(0, 1)), gap_pick());
					cnt++;
				end
				send_word(UPDATE, pool_pc[s], t, gap_pick());
				cnt++;
			end else if (r < 90) begin
				send_word(UPDATE, $urandom(), 1'($urandom_range(0, 1)), gap_pick());
				cnt++;
			end else begin
				send_word(LOOKUP, $urandom(), 1'($urandom_range(0, 1)), gap_pick());
				cnt++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		func = LOOKUP;
		branch_pc = '0;
		outcome_taken = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_fresh_tables();
		test_counter_saturation();
		test_shift_extremes();

		set_shift(SHIFT_RESET);
		test_branch_stream(500);
		set_shift(5'd0);
		test_branch_stream(300);
		set_shift(5'd31);
		test_branch_stream(200);
		set_shift(SHIFT_W'($urandom_range(1, 30)));
		test_branch_stream(350);
		// closing stretch back to back
		idle_on = 1'b0;
		set_shift(SHIFT_W'($urandom_range(3, 12)));
		test_branch_stream(450);

		start = 1'b0;
		for (int i = 0; i < 2000 && guess_q.size() != 0; i++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (guess_q.size() != 0)
			flag($sformatf("%0d results never arrived", guess_q.size()));

		$display("Sent %0d words (%0d updates) over %0d pc_shift settings, checked %0d results",
			n_words, n_updates, n_shifts, n_results);
		$display("Global predictor chosen in %0d results, %0d errors", n_global_sel, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
